// File: design/lidar_column_ground_segmenter_defines.svh
// ----------------------------------------------------------------------------
// Lidar column ground segmenter: assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef LIDAR_COLUMN_GROUND_SEGMENTER_DEFINES_SVH
`define LIDAR_COLUMN_GROUND_SEGMENTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define LCGS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lidar column ground segmenter: property failed");

// Next-cycle implication, disabled while reset is asserted
`define LCGS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lidar column ground segmenter: property failed");

`endif

// File: design/lcgs_pkg.sv
// ----------------------------------------------------------------------------
// Lidar column ground segmenter package
// Word types, opcodes and the structs between the sequencer and the
// threshold unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lcgs_pkg;

	// Opcodes of an input word
	localparam logic OP_TABLE_WR = 1'b0;
	localparam logic OP_POINT    = 1'b1;

	// Accumulated threshold width and saturation value
	localparam int          ACC_W      = 22;
	localparam logic [21:0] THRESH_SAT = 22'h3FFFFF;

	// Point count saturation
	localparam logic [6:0] COUNT_MAX = 7'd127;

	typedef struct packed {
		logic               op;
		logic [5:0]         row;
		logic [10:0]        column;
		logic [17:0]        range_mm;
		logic signed [15:0] height_mm;
		logic [15:0]        table_value;
		logic               last_in_column;
	} in_word_t;

	typedef struct packed {
		logic [10:0] seg_column;
		logic [5:0]  first_row;
		logic [5:0]  end_row;
		logic [6:0]  point_count;
		logic        is_obstacle;
		logic        last_result;
	} out_word_t;

	// Table write request
	typedef struct packed {
		logic        en;
		logic [5:0]  idx;
		logic [15:0] data;
	} tbl_wr_t;

	// Threshold walk request: sum entries from_row .. to_row-1
	typedef struct packed {
		logic       start;
		logic [5:0] from_row;
		logic [5:0] to_row;
	} thr_req_t;

	// Threshold walk response
	typedef struct packed {
		logic             done;
		logic [ACC_W-1:0] sum;
	} thr_rsp_t;

endpackage

`default_nettype wire

// File: design/lcgs_thresh_unit.sv
// ----------------------------------------------------------------------------
// Threshold table and accumulator
// Holds the per-row range-jump table and walks it one entry per cycle,
// adding entries into a saturating 22-bit sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lcgs_thresh_unit #(
	parameter int RINGS = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire lcgs_pkg::tbl_wr_t  wr,
	input  wire lcgs_pkg::thr_req_t req,
	output lcgs_pkg::thr_rsp_t    rsp
);

	localparam int IDX_W = (RINGS > 1) ? $clog2(RINGS) : 1;

	logic [15:0] tbl_mem [RINGS];

	logic                       busy_q;
	logic [5:0]                 idx_q;
	logic [5:0]                 end_q;
	logic [lcgs_pkg::ACC_W-1:0] acc_q;
	logic                       done_q;
	logic                       rd_use_s1;
	logic [15:0]                rd_data_s1;

	logic                     issue;
	logic                     idx_in_range;
	logic [lcgs_pkg::ACC_W:0] acc_sum;

	// Issue one read per cycle while rows remain
	assign issue        = busy_q && (idx_q < end_q);
	assign idx_in_range = 32'(idx_q) < RINGS;
	assign acc_sum      = {1'b0, acc_q} + {{(lcgs_pkg::ACC_W - 15){1'b0}}, rd_data_s1};

	// Table write port; drop writes beyond the table
	always_ff @(posedge clk) begin
		if (wr.en && (32'(wr.idx) < RINGS)) begin
			tbl_mem[IDX_W'(wr.idx)] <= wr.data;
		end
	end

	// Registered table read
	always_ff @(posedge clk) begin
		if (issue) begin
			rd_data_s1 <= tbl_mem[IDX_W'(idx_q)];
		end
	end

	// Walk control and saturating accumulate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			idx_q     <= '0;
			end_q     <= '0;
			acc_q     <= '0;
			done_q    <= 1'b0;
			rd_use_s1 <= 1'b0;
		end else begin
			done_q    <= 1'b0;
			rd_use_s1 <= issue && idx_in_range;
			if (req.start) begin
				busy_q <= 1'b1;
				idx_q  <= req.from_row;
				end_q  <= req.to_row;
			end else if (busy_q) begin
				if (issue) begin
					idx_q <= idx_q + 6'd1;
				end else begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
			if (req.start) begin
				acc_q <= '0;
			end else if (rd_use_s1) begin
				acc_q <= acc_sum[lcgs_pkg::ACC_W] ? lcgs_pkg::THRESH_SAT
				                                  : acc_sum[lcgs_pkg::ACC_W-1:0];
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.sum  = acc_q;

endmodule

`default_nettype wire

// File: design/lidar_column_ground_segmenter.sv
// ----------------------------------------------------------------------------
// Lidar column ground segmenter
// Splits each depth-image column into segments at range jumps and
// reports every closed segment with a ground or obstacle flag.
// ----------------------------------------------------------------------------
// Words enter one at a time; the block holds in_stall high while a point is
// at work. A table write stays in ST_IDLE. A point that opens the first
// segment stays in ST_IDLE too, or goes to ST_LAST for a result if it is
// the last of its column. A point in the same column whose row is above the
// previous point's row waits in ST_SUM while the range-jump threshold is
// summed one table entry per cycle through the single read port of the
// threshold table and one saturating adder. A point that closes a segment
// goes through ST_CLOSE, and ST_LAST for the column's last result, and waits
// there while out_stall holds the output register. Results leave through
// one output register, so a new word is taken while a finished result waits.
`timescale 1ns / 1ps
`default_nettype none

module lidar_column_ground_segmenter #(
	parameter int RINGS = 64
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire lcgs_pkg::in_word_t  in_word,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output lcgs_pkg::out_word_t      out_word,
	input  wire logic                cfg_wr_en,
	input  wire logic [15:0]         cfg_wr_data
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SUM   = 2'd1;
	localparam logic [1:0] ST_CLOSE = 2'd2;
	localparam logic [1:0] ST_LAST  = 2'd3;

	logic [1:0]          state_q;
	logic [1:0]          state_d;
	lcgs_pkg::in_word_t  item_q;
	logic [15:0]         vthr_q;

	logic               open_q;
	logic [5:0]         prev_row_q;
	logic [17:0]        prev_range_q;
	logic [5:0]         start_row_q;
	logic [6:0]         points_q;
	logic signed [15:0] hmax_q;
	logic signed [15:0] hmin_q;
	logic [10:0]        col_q;

	lcgs_pkg::out_word_t out_q;
	logic                out_valid_q;

	lcgs_pkg::tbl_wr_t  tbl_wr;
	lcgs_pkg::thr_req_t thr_req;
	lcgs_pkg::thr_rsp_t thr_rsp;

	logic               accept;
	logic               slot_free;
	logic               seg_start;
	lcgs_pkg::in_word_t seg_src;
	logic               seg_join;
	logic               seg_clear;
	logic               out_load;
	logic               out_last;
	logic [17:0]        range_diff;
	logic signed [16:0] span;
	logic               obstacle;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign slot_free = !out_valid_q || !out_stall;

	// Table writes go straight to the threshold unit
	assign tbl_wr.en   = accept && (in_word.op == lcgs_pkg::OP_TABLE_WR);
	assign tbl_wr.idx  = in_word.row;
	assign tbl_wr.data = in_word.table_value;

	lcgs_thresh_unit #(
		.RINGS(RINGS)
	) u_thresh (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (tbl_wr),
		.req   (thr_req),
		.rsp   (thr_rsp)
	);

	// Range change against the previous point of the segment
	always_comb begin
		if (item_q.range_mm >= prev_range_q) begin
			range_diff = item_q.range_mm - prev_range_q;
		end else begin
			range_diff = prev_range_q - item_q.range_mm;
		end
	end

	// Height span of the open segment and obstacle decision
	assign span     = {hmax_q[15], hmax_q} - {hmin_q[15], hmin_q};
	assign obstacle = (points_q > 7'd1) && (span > $signed({1'b0, vthr_q}));

	// Sequencer
	always_comb begin
		state_d          = state_q;
		thr_req.start    = 1'b0;
		thr_req.from_row = prev_row_q;
		thr_req.to_row   = in_word.row;
		seg_start        = 1'b0;
		seg_src          = item_q;
		seg_join         = 1'b0;
		seg_clear        = 1'b0;
		out_load         = 1'b0;
		out_last         = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept && (in_word.op == lcgs_pkg::OP_POINT)) begin
					if (!open_q) begin
						seg_start = 1'b1;
						seg_src   = in_word;
						state_d   = in_word.last_in_column ? ST_LAST : ST_IDLE;
					end else if (in_word.column != col_q) begin
						state_d = ST_CLOSE;
					end else if (prev_row_q < in_word.row) begin
						thr_req.start = 1'b1;
						state_d       = ST_SUM;
					end else begin
						state_d = ST_CLOSE;
					end
				end
			end
			ST_SUM: begin
				if (thr_rsp.done) begin
					if ({{(lcgs_pkg::ACC_W - 18){1'b0}}, range_diff} < thr_rsp.sum) begin
						seg_join = 1'b1;
						state_d  = item_q.last_in_column ? ST_LAST : ST_IDLE;
					end else begin
						state_d = ST_CLOSE;
					end
				end
			end
			ST_CLOSE: begin
				if (slot_free) begin
					out_load  = 1'b1;
					out_last  = !item_q.last_in_column;
					seg_start = 1'b1;
					state_d   = item_q.last_in_column ? ST_LAST : ST_IDLE;
				end
			end
			ST_LAST: begin
				if (slot_free) begin
					out_load  = 1'b1;
					out_last  = 1'b1;
					seg_clear = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold the accepted word while it is at work
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_word;
		end
	end

	// State, register and segment bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			vthr_q       <= 16'd80;
			open_q       <= 1'b0;
			prev_row_q   <= '0;
			prev_range_q <= '0;
			start_row_q  <= '0;
			points_q     <= '0;
			hmax_q       <= '0;
			hmin_q       <= '0;
			col_q        <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				vthr_q <= cfg_wr_data;
			end
			if (seg_start) begin
				open_q       <= 1'b1;
				start_row_q  <= seg_src.row;
				prev_row_q   <= seg_src.row;
				prev_range_q <= seg_src.range_mm;
				points_q     <= 7'd1;
				hmax_q       <= seg_src.height_mm;
				hmin_q       <= seg_src.height_mm;
				col_q        <= seg_src.column;
			end else if (seg_join) begin
				if (points_q != lcgs_pkg::COUNT_MAX) begin
					points_q <= points_q + 7'd1;
				end
				if (item_q.height_mm > hmax_q) begin
					hmax_q <= item_q.height_mm;
				end
				if (item_q.height_mm < hmin_q) begin
					hmin_q <= item_q.height_mm;
				end
				prev_row_q   <= item_q.row;
				prev_range_q <= item_q.range_mm;
			end else if (seg_clear) begin
				open_q <= 1'b0;
			end
		end
	end

	// Output register: load a closed segment, drop a word once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.seg_column  <= col_q;
			out_q.first_row   <= start_row_q;
			out_q.end_row     <= prev_row_q;
			out_q.point_count <= points_q;
			out_q.is_obstacle <= obstacle;
			out_q.last_result <= out_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

endmodule

`default_nettype wire

// File: design/lcgs_checker.sv
// ----------------------------------------------------------------------------
// Lidar column ground segmenter port checker
// Watches the top level's ports and checks result words over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "lidar_column_ground_segmenter_defines.svh"

module lcgs_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                out_valid,
	input wire logic                out_stall,
	input wire lcgs_pkg::out_word_t out_word
);

	// Hold a stalled result word
	`LCGS_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_word))

	// Every reported segment has at least one point
	`LCGS_ASSERT_IMP(a_count_nonzero, clk, arst_n, out_valid, out_word.point_count != 7'd0)

	// Segment rows ascend from first to end
	`LCGS_ASSERT_IMP(a_row_order, clk, arst_n, out_valid, out_word.first_row <= out_word.end_row)

	// A single-point segment spans one row and is never an obstacle
	`LCGS_ASSERT_IMP(a_single_point, clk, arst_n, out_valid && (out_word.point_count == 7'd1), !out_word.is_obstacle && (out_word.first_row == out_word.end_row))

endmodule

bind lidar_column_ground_segmenter lcgs_checker u_lcgs_checker (.*);

`default_nettype wire

// File: sim/tb_lidar_column_ground_segmenter.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Lidar column ground segmenter testbench
// Fills the threshold table, then sends directed and random column point
// streams under random idling on both sides. A segment tracker predicts every
// closed segment, and each reported segment is checked field by field.
// ---------------------------------------------------------------------------
module tb_lidar_column_ground_segmenter;

	localparam int     NUM_ROWS      = 64;
	localparam int     SETTLE_CYCLES = 100;
	localparam int     LONG_HOLD     = 400;
	localparam int     PHASE_WORDS   = 190;
	localparam int     NUM_PHASES    = 6;
	localparam longint LIMIT_NS      = 6_000_000;

	// Tracks the open segment of the current column and queues closed segments
	class segment_tracker;
		logic [15:0]         ring_limit [NUM_ROWS];
		logic [15:0]         vert_limit;
		bit                  seg_open;
		logic [5:0]          last_row;
		logic [17:0]         last_range;
		logic [5:0]          seg_first_row;
		logic [6:0]          seg_points;
		logic signed [15:0]  height_hi;
		logic signed [15:0]  height_lo;
		logic [10:0]         seg_col;
		lcgs_pkg::out_word_t expected_segments [$];
		int                  mismatch_count;

		function new();
			foreach (ring_limit[i]) ring_limit[i] = '0;
			vert_limit     = 16'd80;
			seg_open       = 1'b0;
			last_row       = '0;
			last_range     = '0;
			seg_first_row  = '0;
			seg_points     = '0;
			height_hi      = '0;
			height_lo      = '0;
			seg_col        = '0;
			mismatch_count = 0;
		endfunction

		function void set_vertical_limit(logic [15:0] v);
			vert_limit = v;
		endfunction

		// Sum table entries from_row .. to_row-1, saturating at 22 bits
		function int unsigned jump_limit(logic [5:0] from_row, logic [5:0] to_row);
			int unsigned acc;
			acc = 0;
			for (int r = from_row; r < to_row; r++) begin
				acc += ring_limit[r];
				if (acc > lcgs_pkg::THRESH_SAT)
					acc = lcgs_pkg::THRESH_SAT;
			end
			return acc;
		endfunction

		function lcgs_pkg::out_word_t closed_segment();
			lcgs_pkg::out_word_t s;
			int                  span;
			int                  limit;
			span          = height_hi - height_lo;
			limit         = vert_limit;
			s.seg_column  = seg_col;
			s.first_row   = seg_first_row;
			s.end_row     = last_row;
			s.point_count = seg_points;
			s.is_obstacle = (seg_points > 7'd1) && (span > limit);
			s.last_result = 1'b0;
			return s;
		endfunction

		function void open_segment(lcgs_pkg::in_word_t w);
			seg_open      = 1'b1;
			seg_first_row = w.row;
			last_row      = w.row;
			last_range    = w.range_mm;
			seg_points    = 7'd1;
			height_hi     = $signed(w.height_mm);
			height_lo     = $signed(w.height_mm);
			seg_col       = w.column;
		endfunction

		// Apply one accepted word and queue the segments it closes
		function void absorb_word(lcgs_pkg::in_word_t w);
			lcgs_pkg::out_word_t found [$];
			logic [17:0]         diff;
			if (w.op == lcgs_pkg::OP_TABLE_WR) begin
				ring_limit[w.row] = w.table_value;
				return;
			end
			if (!seg_open) begin
				open_segment(w);
			end else if (w.column != seg_col) begin
				found = {found, closed_segment()};
				open_segment(w);
			end else begin
				diff = (w.range_mm >= last_range) ? w.range_mm - last_range
				                                  : last_range - w.range_mm;
				if (diff < jump_limit(last_row, w.row)) begin
					if (seg_points < lcgs_pkg::COUNT_MAX)
						seg_points++;
					if ($signed(w.height_mm) > height_hi)
						height_hi = $signed(w.height_mm);
					if ($signed(w.height_mm) < height_lo)
						height_lo = $signed(w.height_mm);
					last_row   = w.row;
					last_range = w.range_mm;
				end else begin
					found = {found, closed_segment()};
					open_segment(w);
				end
			end
			if (w.last_in_column) begin
				found = {found, closed_segment()};
				seg_open = 1'b0;
			end
			if (found.size() > 0)
				found[found.size() - 1].last_result = 1'b1;
			foreach (found[i]) expected_segments = {expected_segments, found[i]};
		endfunction

		task report_mismatch(string what);
			mismatch_count++;
			$display("[%0t] segment mismatch: %s", $time, what);
		endtask

		// Compare one reported segment with the oldest prediction
		task check_segment(lcgs_pkg::out_word_t got);
			lcgs_pkg::out_word_t want;
			if (expected_segments.size() == 0) begin
				report_mismatch($sformatf("column %0d rows %0d..%0d reported, none pending",
					got.seg_column, got.first_row, got.end_row));
				return;
			end
			want = expected_segments.pop_front();
			if (got.seg_column !== want.seg_column)
				report_mismatch($sformatf("seg_column %0d, want %0d",
					got.seg_column, want.seg_column));
			if (got.first_row !== want.first_row)
				report_mismatch($sformatf("column %0d first_row %0d, want %0d",
					want.seg_column, got.first_row, want.first_row));
			if (got.end_row !== want.end_row)
				report_mismatch($sformatf("column %0d end_row %0d, want %0d",
					want.seg_column, got.end_row, want.end_row));
			if (got.point_count !== want.point_count)
				report_mismatch($sformatf("column %0d point_count %0d, want %0d",
					want.seg_column, got.point_count, want.point_count));
			if (got.is_obstacle !== want.is_obstacle)
				report_mismatch($sformatf("column %0d is_obstacle %0b, want %0b",
					want.seg_column, got.is_obstacle, want.is_obstacle));
			if (got.last_result !== want.last_result)
				report_mismatch($sformatf("column %0d last_result %0b, want %0b",
					want.seg_column, got.last_result, want.last_result));
		endtask
	endclass

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	lcgs_pkg::in_word_t  in_word;
	logic                out_valid;
	logic                out_stall;
	lcgs_pkg::out_word_t out_word;
	logic                cfg_wr_en;
	logic [15:0]         cfg_wr_data;

	segment_tracker segments = new();
	int             hold_request;
	int             words_sent;

	lidar_column_ground_segmenter uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_word     (in_word),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_word    (out_word),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// End a hung run
	initial begin
		#LIMIT_NS;
		$display("RESULT: ERROR");
		$finish;
	end

	// Table values: mostly moderate radii, with zero, full scale and noise
	function automatic logic [15:0] random_limit();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 80)
			return 16'($urandom_range(300, 4000));
		else if (pick < 90)
			return 16'd0;
		else if (pick < 95)
			return 16'hFFFF;
		return 16'($urandom);
	endfunction

	function automatic lcgs_pkg::in_word_t point_word(logic [5:0] row, logic [10:0] column,
		logic [17:0] rng_mm, logic signed [15:0] height_mm, logic tail);
		lcgs_pkg::in_word_t w;
		w.op             = lcgs_pkg::OP_POINT;
		w.row            = row;
		w.column         = column;
		w.range_mm       = rng_mm;
		w.height_mm      = height_mm;
		w.table_value    = 16'($urandom);
		w.last_in_column = tail;
		return w;
	endfunction

	function automatic lcgs_pkg::in_word_t table_word(logic [5:0] idx, logic [15:0] radius);
		lcgs_pkg::in_word_t w;
		w.op             = lcgs_pkg::OP_TABLE_WR;
		w.row            = idx;
		w.column         = 11'($urandom);
		w.range_mm       = 18'($urandom);
		w.height_mm      = 16'($urandom);
		w.table_value    = radius;
		w.last_in_column = 1'($urandom);
		return w;
	endfunction

	function automatic lcgs_pkg::in_word_t random_word();
		lcgs_pkg::in_word_t w;
		w.op             = 1'($urandom);
		w.row            = 6'($urandom);
		w.column         = 11'($urandom);
		w.range_mm       = 18'($urandom);
		w.height_mm      = 16'($urandom);
		w.table_value    = random_limit();
		w.last_in_column = 1'($urandom);
		return w;
	endfunction

	// Move a range by delta, clamped to the 18-bit field
	function automatic logic [17:0] nudge_range(logic [17:0] base, int delta);
		int moved;
		moved = int'(base) + delta;
		if (moved < 0)
			moved = 0;
		if (moved > 262143)
			moved = 262143;
		return 18'(moved);
	endfunction

	// Move a height by delta, clamped to the signed 16-bit field
	function automatic logic signed [15:0] nudge_height(logic signed [15:0] base, int delta);
		int moved;
		moved = base + delta;
		if (moved < -32768)
			moved = -32768;
		if (moved > 32767)
			moved = 32767;
		return 16'(moved);
	endfunction

	// Row advance: mostly adjacent, some gaps, a few repeats or reversals
	function automatic int row_step();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 70)
			return 1;
		else if (pick < 85)
			return $urandom_range(2, 3);
		else if (pick < 93)
			return $urandom_range(4, 20);
		else if (pick < 97)
			return -$urandom_range(0, 3);
		return $urandom_range(21, 63);
	endfunction

	// Offer one word after a random gap; hold it until taken
	task automatic send_word(lcgs_pkg::in_word_t w);
		int gap;
		gap = $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word  <= w;
		do @(posedge clk); while (in_stall);
		segments.absorb_word(w);
		words_sent++;
	endtask

	// Stop offering and wait until every predicted segment has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (segments.expected_segments.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_vertical_limit(logic [15:0] v);
		wait_drained();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		segments.set_vertical_limit(v);
	endtask

	// Send one column of points; mostly joins, some range and height jumps
	task automatic send_random_column();
		logic [10:0]        column;
		logic [17:0]        rng_mm;
		logic signed [15:0] height;
		int                 n_points;
		int                 next_row;
		int                 step;
		int                 pick;
		bit                 full_sweep;
		bit                 close_it;
		bit                 tail;
		column     = 11'($urandom);
		full_sweep = ($urandom_range(0, 49) == 0);
		n_points   = full_sweep ? 64 : $urandom_range(1, 8);
		next_row   = full_sweep ? 0 : $urandom_range(0, 40);
		rng_mm     = 18'($urandom);
		height     = 16'($urandom);
		close_it   = full_sweep || ($urandom_range(0, 9) != 0);
		for (int i = 0; i < n_points; i++) begin
			if (!full_sweep && $urandom_range(0, 39) == 0)
				send_word(table_word(6'($urandom), random_limit()));
			step = full_sweep ? 1 : row_step();
			tail = (i == n_points - 1) || (next_row + step > 63);
			send_word(point_word(6'(next_row), column, rng_mm, height, close_it && tail));
			if (tail)
				break;
			next_row = (next_row + step < 0) ? 0 : next_row + step;
			pick = $urandom_range(0, 99);
			if (full_sweep || pick < 80)
				rng_mm = nudge_range(rng_mm, $urandom_range(0, 200) - 100);
			else if (pick < 95)
				rng_mm = nudge_range(rng_mm, $urandom_range(0, 10000) - 5000);
			else
				rng_mm = 18'($urandom);
			pick = $urandom_range(0, 99);
			if (pick < 60)
				height = nudge_height(height, $urandom_range(0, 80) - 40);
			else if (pick < 90)
				height = nudge_height(height, $urandom_range(0, 3000) - 1500);
			else
				height = 16'($urandom);
		end
	endtask

	task automatic run_directed();
		// Full height swing across adjacent rows: obstacle
		send_word(table_word(6'd0, 16'd4000));
		send_word(point_word(6'd0, 11'd0, 18'd0, 16'sh8000, 1'b0));
		send_word(point_word(6'd1, 11'd0, 18'd10, 16'sh7FFF, 1'b1));
		// Lone point at the top of every field: never an obstacle
		send_word(point_word(6'd63, 11'd2047, 18'h3FFFF, 16'sd0, 1'b1));
		// Repeated row, then a lower row: zero threshold splits each time
		send_word(point_word(6'd10, 11'd5, 18'd1000, 16'sd5, 1'b0));
		send_word(point_word(6'd10, 11'd5, 18'd1000, 16'sd500, 1'b0));
		send_word(point_word(6'd3, 11'd5, 18'd1000, 16'sd0, 1'b1));
		// Column change with a segment open
		send_word(point_word(6'd0, 11'd6, 18'd5000, 16'sd100, 1'b0));
		send_word(point_word(6'd1, 11'd7, 18'd5000, 16'sd100, 1'b1));
		// Zero table entry: equal ranges still split
		send_word(table_word(6'd20, 16'd0));
		send_word(point_word(6'd20, 11'd8, 18'd7000, -16'sd200, 1'b0));
		send_word(point_word(6'd21, 11'd8, 18'd7000, 16'sd200, 1'b1));
		// Full-scale entries: range step one below the sum joins, span just over 80
		send_word(table_word(6'd30, 16'hFFFF));
		send_word(table_word(6'd31, 16'hFFFF));
		send_word(point_word(6'd30, 11'd9, 18'd0, 16'sd0, 1'b0));
		send_word(point_word(6'd32, 11'd9, 18'd131069, 16'sd81, 1'b0));
		// Range step equal to the threshold splits; new column closes column 9
		send_word(table_word(6'd40, 16'd1234));
		send_word(point_word(6'd40, 11'd10, 18'd50000, 16'sd7, 1'b0));
		send_word(point_word(6'd41, 11'd10, 18'd51234, 16'sd7, 1'b1));
		// Widest row gap in one step
		send_word(point_word(6'd0, 11'd11, 18'd100000, -16'sd3, 1'b0));
		send_word(point_word(6'd63, 11'd11, 18'd99999, 16'sd3, 1'b1));
	endtask

	// Accept reported segments with random stall stretches
	initial begin
		int hold;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			hold = $urandom_range(0, 4);
			if ($urandom_range(0, 3) == 0)
				hold = 0;
			if (hold_request > 0) begin
				hold         = hold_request;
				hold_request = 0;
			end
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid);
			segments.check_segment(out_word);
		end
	end

	initial begin
		logic [15:0] limits [NUM_PHASES];
		int          phase_end;
		bit          paused;
		in_valid     = 1'b0;
		in_word      = '0;
		cfg_wr_en    = 1'b0;
		cfg_wr_data  = '0;
		arst_n       = 1'b0;
		hold_request = 0;
		words_sent   = 0;
		paused       = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill the whole table so no threshold sum reads an unwritten entry
		for (int i = 0; i < NUM_ROWS; i++)
			send_word(table_word(6'(i), 16'($urandom_range(300, 4000))));
		run_directed();

		limits = '{16'd0, 16'hFFFF, 16'd80, 16'd1, 16'($urandom), 16'd300};
		for (int p = 0; p < NUM_PHASES; p++) begin
			write_vertical_limit(limits[p]);
			phase_end = words_sent + PHASE_WORDS;
			// Back up the block behind a long output stall
			if (p == 2)
				hold_request = LONG_HOLD;
			while (words_sent < phase_end) begin
				// Pause the sender mid-phase until every segment is out
				if (p == 3 && !paused && words_sent >= phase_end - PHASE_WORDS / 2) begin
					wait_drained();
					paused = 1'b1;
				end
				if ($urandom_range(0, 19) == 0)
					send_word(random_word());
				else
					send_random_column();
			end
		end

		in_valid <= 1'b0;
		while (segments.expected_segments.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (segments.mismatch_count == 0 && segments.expected_segments.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: sim.f
+incdir+design
design/lcgs_pkg.sv
design/lcgs_thresh_unit.sv
design/lidar_column_ground_segmenter.sv
design/lcgs_checker.sv
sim/tb_lidar_column_ground_segmenter.sv
